// ----- rtl/core/bfa_pkg.sv -----
// Shared types and constants for the best-fit block allocator.
// No dependencies.
package bfa_pkg;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_PRELOAD = 2'd1;
    localparam logic [1:0] REQ_ALLOC   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADPRE = 2'd3;

    localparam logic [1:0] UNIT_KB = 2'd1;
    localparam logic [1:0] UNIT_MB = 2'd2;

    localparam logic ADDR_SIZE_UNIT = 1'b0;
    localparam logic ADDR_TOTAL_MEM = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_DONE
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load_req;
        logic scan_reset;
        logic scan_check;
        logic shift_init;
        logic shift_read;
        logic shift_step;
        logic write_entries;
        logic do_clear;
        logic emit;
        logic [1:0] emit_status;
        logic emit_fail;
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] req_type;
        logic       bad_size;
        logic       empty;
        logic       scan_last;
        logic       found;
        logic       room;
        logic       shift_done;
        logic       shift_none;
    } stat_t;

endpackage

// ----- rtl/core/bfa_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/bfa_ctrl.sv -----
// Controller state machine for the best-fit block allocator.
// Depends on bfa_pkg.
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    output cmd_t  cmd,
    input  stat_t stat
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (stat.req_type == REQ_CLEAR)
                begin
                    cmd.do_clear = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.emit_status = ST_OK;
                    state_next = S_DONE;
                end
                else if (stat.req_type != REQ_PRELOAD && stat.req_type != REQ_ALLOC)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_status = ST_NOFIT;
                    cmd.emit_fail = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.bad_size || stat.empty)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_fail = 1'b1;
                    cmd.emit_status = (stat.req_type == REQ_PRELOAD && !stat.bad_size)
                                      ? ST_BADPRE : ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_reset = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_check = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                if (!stat.found)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_fail = 1'b1;
                    cmd.emit_status = (stat.req_type == REQ_PRELOAD) ? ST_BADPRE : ST_NOFIT;
                    state_next = S_DONE;
                end
                else if (!stat.room)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_fail = 1'b1;
                    cmd.emit_status = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                    state_next = stat.shift_none ? S_WRITE : S_SHIFT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.shift_read = 1'b1;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_step = 1'b1;
                state_next = stat.shift_done ? S_WRITE : S_SHIFT_RD;
            end
            S_WRITE:
            begin
                cmd.write_entries = 1'b1;
                if (stat.shift_done)
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_status = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == S_DONE)
        else $error("emit not followed by done");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> !busy)
        else $error("done did not release busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");
endmodule

// ----- rtl/core/bfa_dp.sv -----
// Datapath for the best-fit block allocator: table memories, scan, shift and write.
// Depends on bfa_pkg and bfa_ram.
module bfa_dp
    import bfa_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_BITS   = 32,
    parameter int OWNER_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  unit,
    input  logic [31:0] total_mem,
    input  logic [1:0]  req_type,
    input  logic [7:0]  owner_id,
    input  logic [31:0] req_size,
    input  logic [31:0] start_addr,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  block_index,
    output logic [31:0] block_start,
    output logic [31:0] block_end,
    output logic [6:0]  block_count
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = ADDR_BITS + 1;
    localparam int EW = ADDR_BITS + SW + 1 + OWNER_BITS;
    localparam logic [SW-1:0] SPACE = SW'(1) << ADDR_BITS;

    // request registers
    logic [1:0]            type_reg;
    logic [OWNER_BITS-1:0] own_reg;
    logic [SW-1:0]         sz_reg;
    logic [SW-1:0]         addr_reg;
    logic                  bad_reg;
    logic [SW-1:0]         total_reg;
    logic [CW-1:0]         count_reg, count_next;

    // scan
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic [IW-1:0] best_reg;
    logic [SW-1:0] bsize_reg;
    logic [SW-1:0] bstart_reg;
    logic [SW-1:0] front_reg;

    // shift / write
    logic [IW-1:0] sidx_reg;
    logic [1:0]    extra_reg;
    logic [1:0]    wstep_reg;

    logic           we;
    logic [IW-1:0]  waddr, raddr;
    logic [EW-1:0]  wdata, rdata;

    bfa_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_tab (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    logic [ADDR_BITS-1:0]  e_start;
    logic [SW-1:0]         e_size;
    logic                  e_used;
    assign {e_start, e_size, e_used} = rdata[EW-1:OWNER_BITS];

    function automatic logic [64:0] scale(input logic [31:0] v, input logic [1:0] u);
        logic [64:0] b;
        b = {33'd0, v};
        if (u == UNIT_KB)
        begin
            b = b << 10;
        end
        else if (u == UNIT_MB)
        begin
            b = b << 20;
        end
        return b;
    endfunction

    logic [64:0] sz_full, tot_full;
    assign sz_full  = scale(req_size, unit);
    assign tot_full = scale(total_mem, unit);

    // candidate test for current entry
    logic [SW-1:0] e_start_x, off, room_after, back;
    logic          hit;
    assign e_start_x  = {1'b0, e_start};
    assign off        = addr_reg - e_start_x;
    assign room_after = e_size - off;
    always_comb
    begin
        hit = 1'b0;
        if (!e_used)
        begin
            if (type_reg == REQ_PRELOAD)
            begin
                hit = !found_reg && addr_reg >= e_start_x && off <= e_size
                      && sz_reg <= room_after;
            end
            else
            begin
                hit = e_size >= sz_reg && (!found_reg || e_size < bsize_reg);
            end
        end
    end

    logic [SW-1:0] rem;
    logic          has_front, has_back;
    logic [1:0]    extra_w;
    assign back      = bsize_reg - front_reg - sz_reg;
    assign rem       = bsize_reg - sz_reg;
    assign has_front = (type_reg == REQ_PRELOAD) && front_reg != '0;
    assign has_back  = (type_reg == REQ_PRELOAD) ? (back != '0) : (rem != '0);
    assign extra_w   = {1'b0, has_front} + {1'b0, has_back};

    logic [CW:0] count_sum;
    assign count_sum = {1'b0, count_reg} + {{(CW-1){1'b0}}, extra_w};

    logic [IW-1:0] last_idx;
    assign last_idx = IW'(count_reg - CW'(1));

    assign stat.req_type   = type_reg;
    assign stat.bad_size   = bad_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.scan_last  = (count_reg == '0) ? 1'b1 : (idx_reg == last_idx);
    assign stat.found      = found_reg;
    assign stat.room       = count_sum <= (CW + 1)'(TABLE_DEPTH);
    assign stat.shift_none = (extra_w == 2'd0) || ({1'b0, best_reg} == count_reg - CW'(1));
    assign stat.shift_done = (cmd.write_entries)
                             ? (wstep_reg == 2'd0 || (wstep_reg == 2'd1 && !has_back))
                             : (sidx_reg == best_reg);

    // write-step contents
    logic [IW-1:0]         wr_idx;
    logic [ADDR_BITS-1:0]  wr_start;
    logic [SW-1:0]         wr_size;
    logic                  wr_used;
    logic [OWNER_BITS-1:0] wr_own;
    logic [SW-1:0]         alloc_start;
    logic [IW-1:0]         alloc_idx;
    assign alloc_start = (type_reg == REQ_PRELOAD) ? addr_reg : bstart_reg;
    assign alloc_idx   = has_front ? best_reg + IW'(1) : best_reg;

    always_comb
    begin
        wr_idx = alloc_idx;
        wr_start = alloc_start[ADDR_BITS-1:0];
        wr_size = sz_reg;
        wr_used = 1'b1;
        wr_own = own_reg;
        if (wstep_reg == 2'd2)
        begin
            wr_idx = best_reg;
            wr_start = bstart_reg[ADDR_BITS-1:0];
            wr_size = front_reg;
            wr_used = 1'b0;
            wr_own = '0;
        end
        else if (wstep_reg == 2'd0)
        begin
            wr_idx = alloc_idx + IW'(1);
            wr_start = ADDR_BITS'(alloc_start + sz_reg);
            wr_size = (type_reg == REQ_PRELOAD) ? back : rem;
            wr_used = 1'b0;
            wr_own = '0;
        end
    end

    always_comb
    begin
        we = 1'b0;
        waddr = wr_idx;
        wdata = {wr_start, wr_size, wr_used, wr_own};
        raddr = cmd.shift_init ? last_idx : (cmd.scan_reset ? '0 : idx_reg);
        if (cmd.shift_read)
        begin
            raddr = sidx_reg;
        end
        if (cmd.shift_step)
        begin
            we = 1'b1;
            waddr = IW'(sidx_reg + IW'(extra_reg));
            wdata = rdata;
        end
        else if (cmd.write_entries)
        begin
            we = (wstep_reg != 2'd0) || has_back;
        end
        else if (cmd.do_clear)
        begin
            we = total_reg != '0;
            waddr = '0;
            wdata = {{ADDR_BITS{1'b0}}, total_reg, 1'b0, {OWNER_BITS{1'b0}}};
        end
        if (cmd.scan_check && !stat.scan_last)
        begin
            raddr = idx_reg + IW'(1);
        end
        if (cmd.shift_step && !stat.shift_done)
        begin
            raddr = sidx_reg - IW'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_clear)
        begin
            count_next = (total_reg != '0) ? CW'(1) : '0;
        end
        else if (cmd.write_entries && stat.shift_done)
        begin
            count_next = CW'(count_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done <= 1'b0;
            wstep_reg <= '0;
        end
        else
        begin
            done <= cmd.emit;
            count_reg <= count_next;
            if (cmd.shift_init)
            begin
                wstep_reg <= has_front ? 2'd2 : 2'd1;
            end
            else if (cmd.write_entries)
            begin
                wstep_reg <= wstep_reg - 2'd1;
            end
        end
    end

    // reset state: count of zero; entry zero is set up by the first clear
    logic boot_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_reg <= 1'b1;
        end
        else
        begin
            boot_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            type_reg  <= req_type;
            own_reg   <= owner_id[OWNER_BITS-1:0];
            sz_reg    <= SW'(sz_full);
            addr_reg  <= {1'b0, start_addr[ADDR_BITS-1:0]};
            bad_reg   <= sz_full == '0 || sz_full > 65'(SPACE);
            total_reg <= (tot_full > 65'(SPACE)) ? SPACE : SW'(tot_full);
        end
        if (cmd.scan_reset)
        begin
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.scan_check)
        begin
            if (hit)
            begin
                found_reg  <= 1'b1;
                best_reg   <= idx_reg;
                bsize_reg  <= e_size;
                bstart_reg <= e_start_x;
                front_reg  <= (type_reg == REQ_PRELOAD) ? off : '0;
            end
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.shift_init)
        begin
            sidx_reg  <= last_idx;
            extra_reg <= extra_w;
        end
        if (cmd.shift_step)
        begin
            sidx_reg <= sidx_reg - IW'(1);
        end
        if (cmd.emit)
        begin
            status <= cmd.emit_status;
            if (cmd.emit_fail)
            begin
                block_index <= '0;
                block_start <= '0;
                block_end   <= '0;
                block_count <= 7'(count_reg);
            end
            else if (cmd.do_clear)
            begin
                block_index <= '0;
                block_start <= '0;
                block_end   <= (total_reg != '0) ? 32'(total_reg - SW'(1)) : '0;
                block_count <= (total_reg != '0) ? 7'd1 : 7'd0;
            end
            else
            begin
                block_index <= 6'(alloc_idx);
                block_start <= 32'(alloc_start);
                block_end   <= 32'(alloc_start + sz_reg - SW'(1));
                block_count <= 7'(count_next);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift_step && cmd.write_entries))
        else $error("shift and write overlap");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entries |-> found_reg)
        else $error("write without a found block");
    assert property (@(posedge clk) disable iff (!rst_n)
        boot_reg |-> !done)
        else $error("result during reset");
endmodule

// ----- rtl/core/best_fit_block_allocator.sv -----
// Top level of the best-fit block allocator: APB registers, controller, datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_dp.
// A clear or a request rejected before the scan is settled in the prepare state; allocate
// and preload scan every table entry (a table RAM read, then a check, per entry), shift
// the entries after the chosen block up, then write; one request is handled at a time.
// Reset restores size_unit 0 and total_memory 65536 and sets up a one-block table
// through an automatic clear pass, during which busy stays high.
module best_fit_block_allocator
    import bfa_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_BITS   = 32,
    parameter int OWNER_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  owner_id,
    input  logic [31:0] req_size,
    input  logic [31:0] start_addr,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  block_index,
    output logic [31:0] block_start,
    output logic [31:0] block_end,
    output logic [6:0]  block_count
);
    logic [1:0]  unit_reg;
    logic [31:0] total_reg;
    logic        init_reg;
    logic        ctrl_busy;
    logic        dp_done;
    cmd_t        cmd;
    stat_t       stat;

    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr[2])
            ADDR_SIZE_UNIT: prdata = {30'd0, unit_reg};
            ADDR_TOTAL_MEM: prdata = total_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg  <= 2'd0;
            total_reg <= 32'd65536;
            init_reg  <= 1'b1;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == ADDR_SIZE_UNIT)
                begin
                    unit_reg <= pwdata[1:0];
                end
                else
                begin
                    total_reg <= pwdata;
                end
            end
            if (!ctrl_busy)
            begin
                init_reg <= 1'b0;
            end
        end
    end

    // the reset clear runs as an internal request whose result is hidden
    logic init_run_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_run_reg <= 1'b0;
        end
        else if (init_reg && !ctrl_busy)
        begin
            init_run_reg <= 1'b1;
        end
        else if (!ctrl_busy)
        begin
            init_run_reg <= 1'b0;
        end
    end

    logic        go;
    logic [1:0]  type_in;
    assign go      = init_reg ? 1'b1 : start;
    assign type_in = init_reg ? REQ_CLEAR : req_type;
    assign busy    = ctrl_busy || init_reg;
    assign done    = dp_done && !init_run_reg;

    bfa_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(go),
        .busy (ctrl_busy),
        .cmd  (cmd),
        .stat (stat)
    );

    bfa_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ADDR_BITS  (ADDR_BITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .unit       (init_reg ? 2'd0 : unit_reg),
        .total_mem  (init_reg ? 32'd65536 : total_reg),
        .req_type   (type_in),
        .owner_id   (owner_id),
        .req_size   (req_size),
        .start_addr (start_addr),
        .done       (dp_done),
        .status     (status),
        .block_index(block_index),
        .block_start(block_start),
        .block_end  (block_end),
        .block_count(block_count)
    );
endmodule

// ----- bench/best_fit_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for best_fit_block_allocator: APB setup, random requests,
// scoreboard of predicted allocation results. Depends on bfa_pkg and the RTL top.
module best_fit_block_allocator_tb;
    import bfa_pkg::*;

    localparam int DEPTH = 64;
    localparam longint SPACE = 64'd1 << 32;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  index;
        logic [31:0] bstart;
        logic [31:0] bend;
        logic [6:0]  count;
    } alloc_result_t;

    class alloc_scoreboard;
        alloc_result_t pending[$];
        int mismatches;
        int checked;
        logic [1:0] unit_sel;
        logic [31:0] total_units;
        longint blk_start[DEPTH];
        longint blk_size[DEPTH];
        bit blk_used[DEPTH];
        int blk_count;

        function new();
            mismatches = 0;
            checked = 0;
            unit_sel = 2'd0;
            total_units = 32'd65536;
            rebuild();
        endfunction

        function longint scale(logic [31:0] v);
            longint b;
            b = longint'(v);
            if (unit_sel == UNIT_KB)
                b = b * 1024;
            else if (unit_sel == UNIT_MB)
                b = b * 1048576;
            return b;
        endfunction

        function void rebuild();
            longint tot;
            tot = scale(total_units);
            if (tot > SPACE)
                tot = SPACE;
            blk_count = 0;
            if (tot > 0)
            begin
                blk_start[0] = 0;
                blk_size[0] = tot;
                blk_used[0] = 0;
                blk_count = 1;
            end
        endfunction

        function void shift_up(int pos, int n);
            for (int k = blk_count - 1; k >= pos; k--)
            begin
                blk_start[k + n] = blk_start[k];
                blk_size[k + n] = blk_size[k];
                blk_used[k + n] = blk_used[k];
            end
        endfunction

        function void push_result(logic [1:0] st, int idx, longint bs, longint be);
            alloc_result_t r;
            r.status = st;
            r.index = idx[5:0];
            r.bstart = bs[31:0];
            r.bend = be[31:0];
            r.count = blk_count[6:0];
            pending.push_back(r);
        endfunction

        function void note_request(logic [1:0] kind, logic [31:0] size_units,
                                   logic [31:0] addr_in);
            longint sz;
            longint addr;
            longint front;
            longint back;
            int extra;
            int pos;
            int best;
            sz = scale(size_units);
            addr = longint'(addr_in);
            if (kind == REQ_CLEAR)
            begin
                rebuild();
                if (blk_count == 0)
                    push_result(ST_OK, 0, 0, 0);
                else
                    push_result(ST_OK, 0, 0, blk_size[0] - 1);
                return;
            end
            if (kind != REQ_PRELOAD && kind != REQ_ALLOC)
            begin
                push_result(ST_NOFIT, 0, 0, 0);
                return;
            end
            if (sz == 0 || sz > SPACE)
            begin
                push_result(ST_NOFIT, 0, 0, 0);
                return;
            end
            if (kind == REQ_PRELOAD)
            begin
                for (int i = 0; i < blk_count; i++)
                begin
                    if (!blk_used[i] && addr >= blk_start[i]
                        && addr - blk_start[i] <= blk_size[i]
                        && sz <= blk_size[i] - (addr - blk_start[i]))
                    begin
                        front = addr - blk_start[i];
                        back = blk_size[i] - front - sz;
                        extra = (front > 0) + (back > 0);
                        if (blk_count + extra > DEPTH)
                        begin
                            push_result(ST_FULL, 0, 0, 0);
                            return;
                        end
                        if (i + 1 < blk_count)
                            shift_up(i + 1, extra);
                        pos = i;
                        if (front > 0)
                        begin
                            blk_size[pos] = front;
                            blk_used[pos] = 0;
                            pos++;
                        end
                        blk_start[pos] = addr;
                        blk_size[pos] = sz;
                        blk_used[pos] = 1;
                        if (back > 0)
                        begin
                            blk_start[pos + 1] = addr + sz;
                            blk_size[pos + 1] = back;
                            blk_used[pos + 1] = 0;
                        end
                        blk_count += extra;
                        push_result(ST_OK, pos, addr, addr + sz - 1);
                        return;
                    end
                end
                push_result(ST_BADPRE, 0, 0, 0);
                return;
            end
            best = -1;
            for (int i = 0; i < blk_count; i++)
                if (!blk_used[i] && blk_size[i] >= sz
                    && (best < 0 || blk_size[i] < blk_size[best]))
                    best = i;
            if (best < 0)
            begin
                push_result(ST_NOFIT, 0, 0, 0);
                return;
            end
            back = blk_size[best] - sz;
            if (back > 0 && blk_count >= DEPTH)
            begin
                push_result(ST_FULL, 0, 0, 0);
                return;
            end
            blk_size[best] = sz;
            blk_used[best] = 1;
            if (back > 0)
            begin
                if (best + 1 < blk_count)
                    shift_up(best + 1, 1);
                blk_start[best + 1] = blk_start[best] + sz;
                blk_size[best + 1] = back;
                blk_used[best + 1] = 0;
                blk_count++;
            end
            push_result(ST_OK, best, blk_start[best], blk_start[best] + sz - 1);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending, status %0d", got.status);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status || got.index !== want.index
                || got.bstart !== want.bstart || got.bend !== want.bend
                || got.count !== want.count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: expected st=%0d idx=%0d %h..%h cnt=%0d,",
                              " got st=%0d idx=%0d %h..%h cnt=%0d"},
                             want.status, want.index, want.bstart, want.bend, want.count,
                             got.status, got.index, got.bstart, got.bend, got.count);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [7:0]  owner_id;
    logic [31:0] req_size;
    logic [31:0] start_addr;
    logic        done;
    logic [1:0]  status;
    logic [5:0]  block_index;
    logic [31:0] block_start;
    logic [31:0] block_end;
    logic [6:0]  block_count;

    alloc_scoreboard sb;
    int cycles;
    int requests;

    best_fit_block_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .req_type(req_type), .owner_id(owner_id), .req_size(req_size),
        .start_addr(start_addr),
        .done(done), .status(status), .block_index(block_index),
        .block_start(block_start), .block_end(block_end), .block_count(block_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("best_fit_block_allocator_tb NOT OK");
            $finish;
        end
    end

    // check each transaction on the result side
    always @(posedge clk)
    begin
        alloc_result_t r;
        if (rst_n && done)
        begin
            r.status = status;
            r.index = block_index;
            r.bstart = block_start;
            r.bend = block_end;
            r.count = block_count;
            sb.check_result(r);
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    task automatic random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return;
        else if (pick < 92)
            idle_cycles($urandom_range(1, 4));
        else
            idle_cycles($urandom_range(10, 200));
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        idle_cycles(300);
    endtask

    task automatic reg_write(logic reg_sel, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == ADDR_SIZE_UNIT)
            sb.unit_sel = value[1:0];
        else
            sb.total_units = value;
    endtask

    task automatic send_request(logic [1:0] kind, logic [7:0] own, logic [31:0] size_units,
                                logic [31:0] addr);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b1;
        req_type <= kind;
        owner_id <= own;
        req_size <= size_units;
        start_addr <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(kind, size_units, addr);
        start <= 1'b0;
        requests++;
    endtask

    function automatic logic [31:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 4096);
        else if (pick < 85)
            return $urandom_range(1, 64);
        else if (pick < 93)
            return $urandom();
        else if (pick < 96)
            return 32'd0;
        else
            return 32'hFFFF_FFFF;
    endfunction

    // one phase: clear, then mostly allocations and preloads into the current layout
    task automatic run_phase(int n);
        logic [1:0] kind;
        logic [31:0] addr;
        int pick;
        send_request(REQ_CLEAR, 8'd0, 32'd0, 32'd0);
        for (int k = 0; k < n; k++)
        begin
            random_gap();
            pick = $urandom_range(0, 99);
            if (pick < 55)
                kind = REQ_ALLOC;
            else if (pick < 90)
                kind = REQ_PRELOAD;
            else if (pick < 95)
                kind = REQ_CLEAR;
            else
                kind = 2'd3;
            if ($urandom_range(0, 3) == 0 || sb.blk_count == 0)
                addr = $urandom();
            else
            begin
                pick = $urandom_range(0, sb.blk_count - 1);
                addr = sb.blk_start[pick][31:0] + $urandom_range(0, 300);
            end
            send_request(kind, 8'($urandom()), random_size(), addr);
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        requests = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        start = 1'b0;
        req_type = REQ_CLEAR;
        owner_id = 8'd0;
        req_size = 32'd0;
        start_addr = 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset layout, field extremes, every request kind
        send_request(REQ_ALLOC, 8'hFF, 32'd100, 32'd0);
        send_request(REQ_ALLOC, 8'h00, 32'd0, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 8'hA5, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_PRELOAD, 8'h5A, 32'd16, 32'd1000);
        send_request(REQ_PRELOAD, 8'h01, 32'd16, 32'd1004);
        send_request(REQ_PRELOAD, 8'h02, 32'd10, 32'hFFFF_FFF0);
        send_request(REQ_PRELOAD, 8'h03, 32'd100, 32'd0);
        send_request(REQ_PRELOAD, 8'h04, 32'd8, 32'd65528);
        send_request(2'd3, 8'hFF, 32'd5, 32'd5);
        send_request(REQ_ALLOC, 8'h10, 32'd900, 32'd0);
        send_request(REQ_ALLOC, 8'h11, 32'd70000, 32'd0);
        // fill the table with single-byte preloads until it reports full
        for (int k = 0; k < 40; k++)
            send_request(REQ_PRELOAD, k[7:0], 32'd1, 32'd2000 + 32'(k * 2));
        drain();

        reg_write(ADDR_SIZE_UNIT, 32'(UNIT_KB));
        reg_write(ADDR_TOTAL_MEM, 32'hFFFF_FFFF);
        send_request(REQ_CLEAR, 8'd0, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 8'h20, 32'd4194304, 32'd0);
        send_request(REQ_CLEAR, 8'd0, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 8'h21, 32'd4194305, 32'd0);
        send_request(REQ_PRELOAD, 8'h22, 32'd1, 32'hFFFF_FC00);
        drain();
        reg_write(ADDR_SIZE_UNIT, 32'(UNIT_MB));
        reg_write(ADDR_TOTAL_MEM, 32'd4096);
        send_request(REQ_CLEAR, 8'd0, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 8'h23, 32'd4096, 32'd0);
        drain();
        reg_write(ADDR_SIZE_UNIT, 32'd3);
        reg_write(ADDR_TOTAL_MEM, 32'd0);
        send_request(REQ_CLEAR, 8'd0, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 8'h24, 32'd1, 32'd0);
        send_request(REQ_PRELOAD, 8'h25, 32'd1, 32'd0);
        drain();

        // random phases across unit and total settings, extremes included
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 6)
                0:
                begin
                    reg_write(ADDR_SIZE_UNIT, 32'd0);
                    reg_write(ADDR_TOTAL_MEM, 32'd65536);
                end
                1:
                begin
                    reg_write(ADDR_SIZE_UNIT, 32'd0);
                    reg_write(ADDR_TOTAL_MEM, 32'd1);
                end
                2:
                begin
                    reg_write(ADDR_SIZE_UNIT, 32'(UNIT_KB));
                    reg_write(ADDR_TOTAL_MEM, $urandom_range(64, 100000));
                end
                3:
                begin
                    reg_write(ADDR_SIZE_UNIT, 32'(UNIT_MB));
                    reg_write(ADDR_TOTAL_MEM, $urandom_range(1, 8192));
                end
                4:
                begin
                    reg_write(ADDR_SIZE_UNIT, 32'd3);
                    reg_write(ADDR_TOTAL_MEM, 32'hFFFF_FFFF);
                end
                default:
                begin
                    reg_write(ADDR_SIZE_UNIT, 32'd0);
                    reg_write(ADDR_TOTAL_MEM, $urandom());
                end
            endcase
            run_phase(145);
        end

        drain();
        $display("Covered %0d requests (%0d results checked) over byte, KB and MB units",
                 requests, sb.checked);
        $display("with clear, preload, best-fit allocate and full-table cases.");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("best_fit_block_allocator_tb OK");
        else
            $display("best_fit_block_allocator_tb NOT OK");
        $finish;
    end
endmodule

// ----- best_fit_block_allocator.f -----
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_ctrl.sv
rtl/core/bfa_dp.sv
rtl/core/best_fit_block_allocator.sv
bench/best_fit_block_allocator_tb.sv
